// ===== rtl/core/rmq_pkg.sv =====
package rmq_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned VAL_W  = 32;

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [VAL_W-1:0]  SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_EVAL,
    ST_FINISH
  } state_e;

endpackage

// ===== rtl/core/rmq_req_if.sv =====
interface rmq_req_if;
  logic                                valid;
  logic                                ready;
  rmq_pkg::op_e                        opcode;
  logic        [rmq_pkg::IDX_W-1:0]    index;
  logic signed [rmq_pkg::VAL_W-1:0]    value;
  logic        [rmq_pkg::IDX_W-1:0]    range_low;
  logic        [rmq_pkg::IDX_W-1:0]    range_high;

  modport source (output valid, opcode, index, value, range_low, range_high, input ready);
  modport sink   (input valid, opcode, index, value, range_low, range_high, output ready);
endinterface

// ===== rtl/core/rmq_rsp_if.sv =====
interface rmq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [rmq_pkg::VAL_W-1:0] median_value;
  logic                             range_error;

  modport source (output valid, median_value, range_error, input ready);
  modport sink   (input valid, median_value, range_error, output ready);
endinterface

// ===== rtl/core/rmq_ram.sv =====
module rmq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/range_median_query.sv =====
// Range lower-median engine. A load transaction writes one signed value into a
// 1024-entry store; a query transaction returns the lower median of the
// inclusive range it names, or an error flag with a zero value when the low
// index is above the high index. A query is answered by a radix select that
// scans the range once per key bit through the single port of the store. The
// block accepts nothing while a query is in progress, but a finished result
// waits in its own output register so that a new transaction can be taken
// meanwhile. Entries must be written before a query reads them.
module range_median_query (
  input  logic             clk_i,
  input  logic             rst_ni,
  rmq_req_if.sink          req_i,
  rmq_rsp_if.source        rsp_o
);

  rmq_pkg::state_e                 state_q, state_d;
  logic [rmq_pkg::ADDR_W-1:0]      ptr_q, ptr_d;
  logic [rmq_pkg::ADDR_W-1:0]      lo_q, lo_d;
  logic [rmq_pkg::ADDR_W-1:0]      hi_q, hi_d;
  logic [rmq_pkg::CNT_W-1:0]       k_q, k_d;
  logic [rmq_pkg::CNT_W-1:0]       zeros_q, zeros_d;
  logic [rmq_pkg::VAL_W-1:0]       prefix_q, prefix_d;
  logic [rmq_pkg::VAL_W-1:0]       hmask_q, hmask_d;
  logic [rmq_pkg::VAL_W-1:0]       bsel_q, bsel_d;
  logic                            err_q, err_d;
  logic                            rd_vld_q, rd_vld_d;
  logic                            out_vld_q, out_vld_d;
  logic [rmq_pkg::VAL_W-1:0]       med_q, med_d;
  logic                            out_err_q, out_err_d;

  logic                            accept;
  logic                            ram_we;
  logic [rmq_pkg::ADDR_W-1:0]      ram_addr;
  logic [rmq_pkg::VAL_W-1:0]       ram_rdata;
  logic [rmq_pkg::VAL_W-1:0]       key;
  logic                            match;
  logic [rmq_pkg::ADDR_W-1:0]      lo_sat, hi_sat;

  assign req_i.ready = (state_q == rmq_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign lo_sat = (32'(req_i.range_low) > 32'(rmq_pkg::ADDR_LAST)) ?
                  rmq_pkg::ADDR_LAST : rmq_pkg::ADDR_W'(req_i.range_low);
  assign hi_sat = (32'(req_i.range_high) > 32'(rmq_pkg::ADDR_LAST)) ?
                  rmq_pkg::ADDR_LAST : rmq_pkg::ADDR_W'(req_i.range_high);

  assign ram_we = accept && (req_i.opcode == rmq_pkg::OP_LOAD) &&
                  (32'(req_i.index) < 32'(rmq_pkg::DEPTH));
  assign ram_addr = (state_q == rmq_pkg::ST_IDLE) ? rmq_pkg::ADDR_W'(req_i.index) : ptr_q;

  rmq_ram #(
    .WIDTH (rmq_pkg::VAL_W),
    .DEPTH (rmq_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (req_i.value),
    .rdata_o (ram_rdata)
  );

  // A key counts when it agrees with the prefix above the current bit and has a zero there.
  assign key   = ram_rdata ^ rmq_pkg::SIGN_FLIP;
  assign match = (((key ^ prefix_q) & hmask_q) == '0) && ((key & bsel_q) == '0);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    k_d       = k_q;
    zeros_d   = zeros_q;
    prefix_d  = prefix_q;
    hmask_d   = hmask_q;
    bsel_d    = bsel_q;
    err_d     = err_q;
    rd_vld_d  = 1'b0;
    out_vld_d = out_vld_q;
    med_d     = med_q;
    out_err_d = out_err_q;

    if (rsp_o.valid && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    if (rd_vld_q && match) begin
      zeros_d = zeros_q + rmq_pkg::CNT_W'(1);
    end

    unique case (state_q)
      rmq_pkg::ST_IDLE: begin
        if (accept && (req_i.opcode == rmq_pkg::OP_QUERY)) begin
          if (req_i.range_low > req_i.range_high) begin
            err_d    = 1'b1;
            prefix_d = rmq_pkg::SIGN_FLIP;
            state_d  = rmq_pkg::ST_FINISH;
          end else begin
            err_d    = 1'b0;
            lo_d     = lo_sat;
            hi_d     = hi_sat;
            ptr_d    = lo_sat;
            k_d      = (rmq_pkg::CNT_W'(hi_sat) - rmq_pkg::CNT_W'(lo_sat) +
                        rmq_pkg::CNT_W'(2)) >> 1;
            zeros_d  = '0;
            prefix_d = '0;
            hmask_d  = '0;
            bsel_d   = rmq_pkg::SIGN_FLIP;
            state_d  = rmq_pkg::ST_SCAN;
          end
        end
      end
      rmq_pkg::ST_SCAN: begin
        rd_vld_d = 1'b1;
        if (ptr_q == hi_q) begin
          state_d = rmq_pkg::ST_WAIT;
        end else begin
          ptr_d = ptr_q + rmq_pkg::ADDR_W'(1);
        end
      end
      rmq_pkg::ST_WAIT: begin
        state_d = rmq_pkg::ST_EVAL;
      end
      rmq_pkg::ST_EVAL: begin
        if (zeros_q < k_q) begin
          k_d      = k_q - zeros_q;
          prefix_d = prefix_q | bsel_q;
        end
        zeros_d = '0;
        hmask_d = hmask_q | bsel_q;
        bsel_d  = bsel_q >> 1;
        ptr_d   = lo_q;
        state_d = bsel_q[0] ? rmq_pkg::ST_FINISH : rmq_pkg::ST_SCAN;
      end
      rmq_pkg::ST_FINISH: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d = 1'b1;
          med_d     = prefix_q ^ rmq_pkg::SIGN_FLIP;
          out_err_d = err_q;
          state_d   = rmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rmq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rmq_pkg::ST_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    k_q       <= k_d;
    zeros_q   <= zeros_d;
    prefix_q  <= prefix_d;
    hmask_q   <= hmask_d;
    bsel_q    <= bsel_d;
    err_q     <= err_d;
    med_q     <= med_d;
    out_err_q <= out_err_d;
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.median_value = med_q;
  assign rsp_o.range_error  = out_err_q;

endmodule

// ===== dv/tb_range_median_query.sv =====
module tb_range_median_query;
  import rmq_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned TAIL_CYCLES  = 100;
  // During a full-depth query there may be no transaction at all.
  localparam int unsigned STALL_LIMIT  = 200000;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct {
    op_e                     opcode;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        range_low;
    logic [IDX_W-1:0]        range_high;
  } request_t;

  typedef struct {
    logic signed [VAL_W-1:0] median;
    logic                    range_error;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rmq_req_if req_if ();
  rmq_rsp_if rsp_if ();

  range_median_query dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  request_t                requests_todo[$];
  answer_t                 answers_due[$];
  answer_t                 due_answer;
  logic signed [VAL_W-1:0] shadow_store [DEPTH];
  bit                      stocked [DEPTH];
  int unsigned             filled;
  int unsigned             failures;
  int unsigned             results_seen;
  int unsigned             req_gap, req_calm;
  int unsigned             rsp_gap, rsp_calm, hold_left;
  int unsigned             idle_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [VAL_W-1:0] lower_median(int unsigned lo, int unsigned hi);
    int unsigned k, below, not_above, i, j;
    k = (hi - lo + 2) / 2;
    for (i = lo; i <= hi; i++) begin
      below = 0;
      not_above = 0;
      for (j = lo; j <= hi; j++) begin
        if (shadow_store[j] < shadow_store[i]) below++;
        if (shadow_store[j] <= shadow_store[i]) not_above++;
      end
      if (below < k && k <= not_above) return shadow_store[i];
    end
    return '0;
  endfunction

  function automatic void track_request(request_t it);
    answer_t ans;
    if (it.opcode == OP_LOAD) begin
      shadow_store[it.index] = it.value;
    end else begin
      if (it.range_low > it.range_high) begin
        ans.median = '0;
        ans.range_error = 1'b1;
      end else begin
        ans.median = lower_median(it.range_low, it.range_high);
        ans.range_error = 1'b0;
      end
      answers_due.insert(answers_due.size(), ans);
    end
  endfunction

  task automatic pick_gap(inout int unsigned gap, inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm != 0) begin
      calm--;
      gap = 0;
    end else if (r < 3) begin
      calm = $urandom_range(20, 80);
      gap = 0;
    end else if (r < 60) begin
      gap = 0;
    end else if (r < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
  endtask

  function automatic logic signed [VAL_W-1:0] draw_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return VAL_MIN;
    if (r < 16) return VAL_MAX;
    if (r < 40) return $urandom_range(6) - 3;
    return $urandom;
  endfunction

  task automatic add_load(int unsigned idx, logic signed [VAL_W-1:0] val);
    request_t it;
    it.opcode     = OP_LOAD;
    it.index      = IDX_W'(idx);
    it.value      = val;
    it.range_low  = IDX_W'($urandom);
    it.range_high = IDX_W'($urandom);
    requests_todo.insert(requests_todo.size(), it);
    stocked[idx] = 1'b1;
    while (filled < DEPTH && stocked[filled]) filled++;
  endtask

  task automatic add_query(int unsigned lo, int unsigned hi);
    request_t it;
    it.opcode     = OP_QUERY;
    it.index      = IDX_W'($urandom);
    it.value      = $urandom;
    it.range_low  = IDX_W'(lo);
    it.range_high = IDX_W'(hi);
    requests_todo.insert(requests_todo.size(), it);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.opcode     <= OP_LOAD;
      req_if.index      <= '0;
      req_if.value      <= '0;
      req_if.range_low  <= '0;
      req_if.range_high <= '0;
      req_gap = 0;
      req_calm = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        track_request(requests_todo.pop_front());
        pick_gap(req_gap, req_calm);
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_gap != 0 || requests_todo.size() == 0) begin
          if (req_gap != 0) req_gap--;
          req_if.valid <= 1'b0;
        end else begin
          req_if.valid      <= 1'b1;
          req_if.opcode     <= requests_todo[0].opcode;
          req_if.index      <= requests_todo[0].index;
          req_if.value      <= requests_todo[0].value;
          req_if.range_low  <= requests_todo[0].range_low;
          req_if.range_high <= requests_todo[0].range_high;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_gap = 0;
      rsp_calm = 0;
      hold_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          $display("%0t: result with none outstanding: median_value %0d range_error %0b",
                   $time, rsp_if.median_value, rsp_if.range_error);
          failures++;
        end else begin
          due_answer = answers_due.pop_front();
          if (rsp_if.median_value !== due_answer.median) begin
            $display("%0t: median_value expected %0d, got %0d",
                     $time, due_answer.median, rsp_if.median_value);
            failures++;
          end
          if (rsp_if.range_error !== due_answer.range_error) begin
            $display("%0t: range_error expected %0b, got %0b",
                     $time, due_answer.range_error, rsp_if.range_error);
            failures++;
          end
        end
        pick_gap(rsp_gap, rsp_calm);
        // Long hold-offs let the engine fill its output register and stall its input.
        if (results_seen == 25 || results_seen == 150) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (rsp_gap != 0) begin
        rsp_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n, r, span, lo, hi, i;
    rst_ni <= 1'b0;
    filled = 0;
    failures = 0;
    results_seen = 0;

    add_load(0, VAL_MIN);
    add_load(1, VAL_MAX);
    add_query(0, 0);
    add_query(1, 1);
    add_query(0, 1);
    add_load(2, 0);
    add_load(3, -1);
    add_load(4, 1);
    add_query(0, 4);
    add_query(1, 4);
    add_load(5, -1);
    add_load(6, -1);
    add_query(3, 6);
    add_load(DEPTH - 1, 32'h2AAA_AAAA);
    add_query(DEPTH - 1, DEPTH - 1);
    add_query(1, 0);
    add_query(DEPTH - 1, 0);
    add_query(DEPTH - 1, DEPTH - 2);
    add_load(7, VAL_MIN);
    add_query(0, 7);
    add_load(0, VAL_MAX);
    add_query(0, 7);

    // Mostly loads that grow the written prefix and queries inside it.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(99);
      if (r < 52) begin
        r = $urandom_range(99);
        if (r < 65 && filled < DEPTH) begin
          add_load(filled, draw_value());
        end else if (r < 90) begin
          add_load($urandom_range(filled - 1), draw_value());
        end else begin
          add_load($urandom_range(DEPTH - 1), draw_value());
        end
      end else if (r < 57) begin
        lo = $urandom_range(1, DEPTH - 1);
        add_query(lo, $urandom_range(lo - 1));
      end else begin
        r = $urandom_range(99);
        if (r < 85) begin
          span = $urandom_range(1, 16);
        end else if (r < 97) begin
          span = $urandom_range(17, 64);
        end else begin
          span = filled;
        end
        if (span > filled) span = filled;
        lo = $urandom_range(filled - span);
        hi = lo + span - 1;
        add_query(lo, hi);
      end
    end

    for (i = 0; i < DEPTH; i++) begin
      if (!stocked[i]) add_load(i, draw_value());
    end
    add_query(0, DEPTH - 1);
    add_query(1, DEPTH - 1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_todo.size() != 0) @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rmq_pkg.sv
rtl/core/rmq_req_if.sv
rtl/core/rmq_rsp_if.sv
rtl/core/rmq_ram.sv
rtl/core/range_median_query.sv
dv/tb_range_median_query.sv
